// ===== hdl/napm_pkg.sv =====
// Shared constants and result codes of the NAT port mapper.
package napm_pkg;
   localparam int POOL_ENTRIES_DEFAULT = 256;
   localparam int KEY_W = 48;
   localparam int TIME_W = 32;
   localparam int PORT_W = 16;
   localparam int IP_W = 32;
   localparam int THR_W = 9;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_PORT_BASE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SWEEP_THR = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_AGE_LIMIT = 2'd2;

   localparam logic [PORT_W-1:0] PORT_BASE_RST = 16'd49152;
   localparam logic [THR_W-1:0] SWEEP_THR_RST = 9'd50;
   localparam logic [TIME_W-1:0] AGE_LIMIT_RST = 32'd3600;

   typedef enum logic [1:0] {
      ST_HIT = 2'd0,
      ST_NEW = 2'd1,
      ST_NOFREE = 2'd2,
      ST_OUTSIDE = 2'd3
   } status_type;
endpackage

// ===== hdl/napm_ram.sv =====
// Generic one-write one-read RAM with registered read data.
module napm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

// ===== hdl/nat_port_mapper_with_aging_unit.sv =====
// Top level of the NAT port mapper with idle aging.
// Usage:
//   req_* carries one item: req_type 0 looks up or allocates a public port for
//   {req_source_ip, req_source_port}; req_type 1 resolves req_public_port.
//   An item is taken when req_valid is high and req_stall low; rsp_* returns one
//   item per request, taken when rsp_valid is high and rsp_stall low.
//   csr_we writes register csr_index (0 port base, 1 sweep threshold, 2 age limit).
// Sequence:
//   reverse lookup: reads the entry RAM through S_REV_RD and S_REV_WAIT to the result register.
//   outbound: one scan of the entry RAM for a hit or a miss; on a miss S_ALLOC and
//   S_ALLOC_WAIT then pop the free list.
//   aging sweep: scan passes of the entry RAM, one pass per evicted
//   entry plus a final pass.
//   One item is worked at a time; the single read port of the entry RAM sets it.
// Reset: a clearing pass initializes the entry and free-list RAMs;
//   no item is accepted during it, configuration writes are taken.
// Stall: a finished result waits in the output register; the next request is
//   accepted meanwhile and its result holds internally until the output frees.
module nat_port_mapper_with_aging_unit #(
   parameter int POOL_ENTRIES = napm_pkg::POOL_ENTRIES_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_type,
   input  logic [napm_pkg::IP_W-1:0]         req_source_ip,
   input  logic [napm_pkg::PORT_W-1:0]       req_source_port,
   input  logic [napm_pkg::PORT_W-1:0]       req_public_port,
   input  logic [napm_pkg::TIME_W-1:0]       req_now_sec,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [napm_pkg::PORT_W-1:0]       rsp_mapped_port,
   output logic [napm_pkg::IP_W-1:0]         rsp_origin_ip,
   output logic [napm_pkg::PORT_W-1:0]       rsp_origin_port,
   output logic [1:0]                        rsp_status,
   input  logic                              csr_we,
   input  logic [napm_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [napm_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import napm_pkg::*;

   localparam int IW = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
   localparam int CNW = $clog2(POOL_ENTRIES + 1);
   localparam int SW = CNW + 1;
   localparam int EW = 1 + KEY_W + TIME_W;
   localparam logic [IW-1:0] LAST_IDX = IW'(POOL_ENTRIES - 1);
   localparam logic [CNW-1:0] FULL_CNT = CNW'(POOL_ENTRIES);

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_LOOKUP, S_SWEEP, S_ALLOC, S_ALLOC_WAIT,
      S_REV_RD, S_REV_WAIT, S_DONE
   } state_type;

   state_type         state_ff, state_in;
   logic [CNW-1:0]    cnt_ff, cnt_in;
   logic              rd_pend_ff, rd_pend_in;
   logic [IW-1:0]     rd_idx_ff, rd_idx_in;
   logic [KEY_W-1:0]  key_ff, key_in;
   logic [TIME_W-1:0] now_ff, now_in;
   logic [IW-1:0]     head_ff, head_in;
   logic [CNW-1:0]    count_ff, count_in;
   logic              found_ff, found_in;
   logic [KEY_W-1:0]  best_key_ff, best_key_in;
   logic [IW-1:0]     best_idx_ff, best_idx_in;
   logic [PORT_W-1:0] res_mapped_ff, res_mapped_in;
   logic [IP_W-1:0]   res_ip_ff, res_ip_in;
   logic [PORT_W-1:0] res_port_ff, res_port_in;
   status_type        res_status_ff, res_status_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [PORT_W-1:0] rsp_mapped_ff, rsp_mapped_in;
   logic [IP_W-1:0]   rsp_ip_ff, rsp_ip_in;
   logic [PORT_W-1:0] rsp_port_ff, rsp_port_in;
   status_type        rsp_status_ff, rsp_status_in;

   logic [PORT_W-1:0] base_ff;
   logic [THR_W-1:0]  thr_ff;
   logic [TIME_W-1:0] age_ff;

   logic              ent_we, fifo_we;
   logic [IW-1:0]     ent_wa, fifo_wa;
   logic [EW-1:0]     ent_wd, ent_rd;
   logic [IW-1:0]     fifo_wd, fifo_rd;

   logic              e_valid, stale, cand, fnd;
   logic [KEY_W-1:0]  e_key, bkey;
   logic [TIME_W-1:0] e_last;
   logic [IW-1:0]     bidx;
   logic [PORT_W-1:0] req_off;
   logic [SW-1:0]     push_sum, push_pos;

   napm_ram #(.WIDTH(EW), .DEPTH(POOL_ENTRIES)) u_ent_ram (
      .clock(clock), .wr_en(ent_we), .wr_addr(ent_wa), .wr_data(ent_wd),
      .rd_addr(cnt_ff[IW-1:0]), .rd_data(ent_rd)
   );

   napm_ram #(.WIDTH(IW), .DEPTH(POOL_ENTRIES)) u_fifo_ram (
      .clock(clock), .wr_en(fifo_we), .wr_addr(fifo_wa), .wr_data(fifo_wd),
      .rd_addr(head_ff), .rd_data(fifo_rd)
   );

   assign e_valid = ent_rd[EW-1];
   assign e_key = ent_rd[KEY_W+TIME_W-1:TIME_W];
   assign e_last = ent_rd[TIME_W-1:0];
   assign stale = (now_ff - e_last) > age_ff;
   assign cand = rd_pend_ff && e_valid && stale && (!found_ff || (e_key < best_key_ff));
   assign fnd = found_ff || cand;
   assign bidx = cand ? rd_idx_ff : best_idx_ff;
   assign bkey = cand ? e_key : best_key_ff;
   assign req_off = req_public_port - base_ff;
   assign push_sum = SW'(head_ff) + SW'(count_ff);
   assign push_pos = (push_sum >= SW'(POOL_ENTRIES)) ? push_sum - SW'(POOL_ENTRIES) : push_sum;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_mapped_port = rsp_mapped_ff;
   assign rsp_origin_ip = rsp_ip_ff;
   assign rsp_origin_port = rsp_port_ff;
   assign rsp_status = rsp_status_ff;

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      rd_pend_in = 1'b0;
      rd_idx_in = rd_idx_ff;
      key_in = key_ff;
      now_in = now_ff;
      head_in = head_ff;
      count_in = count_ff;
      found_in = found_ff;
      best_key_in = best_key_ff;
      best_idx_in = best_idx_ff;
      res_mapped_in = res_mapped_ff;
      res_ip_in = res_ip_ff;
      res_port_in = res_port_ff;
      res_status_in = res_status_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_mapped_in = rsp_mapped_ff;
      rsp_ip_in = rsp_ip_ff;
      rsp_port_in = rsp_port_ff;
      rsp_status_in = rsp_status_ff;
      ent_we = 1'b0;
      ent_wa = rd_idx_ff;
      ent_wd = {1'b1, key_ff, now_ff};
      fifo_we = 1'b0;
      fifo_wa = push_pos[IW-1:0];
      fifo_wd = bidx;

      unique case (state_ff)
         S_CLEAR: begin
            ent_we = 1'b1;
            ent_wa = cnt_ff[IW-1:0];
            ent_wd = '0;
            fifo_we = 1'b1;
            fifo_wa = cnt_ff[IW-1:0];
            fifo_wd = cnt_ff[IW-1:0];
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff[IW-1:0] == LAST_IDX) begin
               head_in = '0;
               count_in = FULL_CNT;
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               key_in = {req_source_ip, req_source_port};
               now_in = req_now_sec;
               cnt_in = '0;
               res_mapped_in = '0;
               res_ip_in = '0;
               res_port_in = '0;
               if (req_type) begin
                  cnt_in = CNW'(req_off[IW-1:0]);
                  if (32'(req_off) >= POOL_ENTRIES) begin
                     res_status_in = ST_OUTSIDE;
                     state_in = S_DONE;
                  end else begin
                     state_in = S_REV_RD;
                  end
               end else begin
                  state_in = S_LOOKUP;
               end
            end
         end
         S_LOOKUP: begin
            if (32'(cnt_ff) < POOL_ENTRIES) begin
               cnt_in = cnt_ff + 1'b1;
               rd_pend_in = 1'b1;
               rd_idx_in = cnt_ff[IW-1:0];
            end
            if (rd_pend_ff) begin
               if (e_valid && (e_key == key_ff)) begin
                  ent_we = 1'b1;
                  res_mapped_in = base_ff + PORT_W'(rd_idx_ff);
                  res_status_in = ST_HIT;
                  rd_pend_in = 1'b0;
                  state_in = S_DONE;
               end else if (rd_idx_ff == LAST_IDX) begin
                  rd_pend_in = 1'b0;
                  cnt_in = '0;
                  found_in = 1'b0;
                  if (32'(count_ff) < 32'(thr_ff)) begin
                     state_in = S_SWEEP;
                  end else begin
                     state_in = S_ALLOC;
                  end
               end
            end
         end
         S_SWEEP: begin
            if (32'(cnt_ff) < POOL_ENTRIES) begin
               cnt_in = cnt_ff + 1'b1;
               rd_pend_in = 1'b1;
               rd_idx_in = cnt_ff[IW-1:0];
            end
            if (cand) begin
               found_in = 1'b1;
               best_key_in = e_key;
               best_idx_in = rd_idx_ff;
            end
            if (rd_pend_ff && (rd_idx_ff == LAST_IDX)) begin
               rd_pend_in = 1'b0;
               cnt_in = '0;
               found_in = 1'b0;
               if (fnd) begin
                  ent_we = 1'b1;
                  ent_wa = bidx;
                  ent_wd = {1'b0, bkey, {TIME_W{1'b0}}};
                  if (count_ff < FULL_CNT) begin
                     fifo_we = 1'b1;
                     count_in = count_ff + 1'b1;
                  end
               end else begin
                  state_in = S_ALLOC;
               end
            end
         end
         S_ALLOC: begin
            if (count_ff == '0) begin
               res_status_in = ST_NOFREE;
               state_in = S_DONE;
            end else begin
               state_in = S_ALLOC_WAIT;
            end
         end
         S_ALLOC_WAIT: begin
            ent_we = 1'b1;
            ent_wa = fifo_rd;
            head_in = (head_ff == LAST_IDX) ? '0 : head_ff + 1'b1;
            count_in = count_ff - 1'b1;
            res_mapped_in = base_ff + PORT_W'(fifo_rd);
            res_status_in = ST_NEW;
            state_in = S_DONE;
         end
         S_REV_RD: begin
            state_in = S_REV_WAIT;
         end
         S_REV_WAIT: begin
            res_ip_in = e_key[KEY_W-1:PORT_W];
            res_port_in = e_key[PORT_W-1:0];
            res_status_in = ST_HIT;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_mapped_in = res_mapped_ff;
               rsp_ip_in = res_ip_ff;
               rsp_port_in = res_port_ff;
               rsp_status_in = res_status_ff;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         cnt_ff <= '0;
         rd_pend_ff <= 1'b0;
         head_ff <= '0;
         count_ff <= FULL_CNT;
         found_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         rd_pend_ff <= rd_pend_in;
         head_ff <= head_in;
         count_ff <= count_in;
         found_ff <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rd_idx_ff <= rd_idx_in;
      key_ff <= key_in;
      now_ff <= now_in;
      best_key_ff <= best_key_in;
      best_idx_ff <= best_idx_in;
      res_mapped_ff <= res_mapped_in;
      res_ip_ff <= res_ip_in;
      res_port_ff <= res_port_in;
      res_status_ff <= res_status_in;
      rsp_mapped_ff <= rsp_mapped_in;
      rsp_ip_ff <= rsp_ip_in;
      rsp_port_ff <= rsp_port_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= PORT_BASE_RST;
         thr_ff <= SWEEP_THR_RST;
         age_ff <= AGE_LIMIT_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_PORT_BASE: base_ff <= csr_wdata[PORT_W-1:0];
            CSR_SWEEP_THR: thr_ff <= csr_wdata[THR_W-1:0];
            CSR_AGE_LIMIT: age_ff <= csr_wdata[TIME_W-1:0];
            default: ;
         endcase
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("free count above pool size");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |=> rsp_valid_ff && $stable(rsp_mapped_ff))
      else $error("stalled result lost");

   a_nofree_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff == ST_NOFREE) |-> (rsp_mapped_ff == '0))
      else $error("pool empty result carries a port");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LOOKUP) |=> $stable(count_ff))
      else $error("free count changed during lookup");
endmodule
